/* rtl/core/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, calendar constants, month-length table and the structs
// passed between the date-add sequencer, its adder and its calendar unit.
// ----------------------------------------------------------------------------
package gda_pkg;

    // field and datapath widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int ADD_W    = 15;
    localparam int REM_W    = 16;   // day count: 365 + 31 + 32767 fits
    localparam int MOD100_W = 7;
    localparam int CENT_W   = 2;    // centuries, kept modulo four

    // calendar constants
    localparam logic [MONTH_W-1:0]  MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0]  MONTH_DEC   = MONTH_W'(12);
    localparam logic [REM_W-1:0]    CENTURY     = REM_W'(100);
    localparam logic [MOD100_W-1:0] MOD100_LAST = MOD100_W'(99);

    typedef logic [DAY_W-1:0] t_len;

    // length of a month; codes outside January to December have no days
    function automatic t_len f_month_len(input logic [MONTH_W-1:0] month,
                                         input logic               leap);
        t_len len;
        case (month)
            4'd1:    len = t_len'(31);
            4'd2:    len = leap ? t_len'(29) : t_len'(28);
            4'd3:    len = t_len'(31);
            4'd4:    len = t_len'(30);
            4'd5:    len = t_len'(31);
            4'd6:    len = t_len'(30);
            4'd7:    len = t_len'(31);
            4'd8:    len = t_len'(31);
            4'd9:    len = t_len'(30);
            4'd10:   len = t_len'(31);
            4'd11:   len = t_len'(30);
            4'd12:   len = t_len'(31);
            default: len = '0;
        endcase
        return len;
    endfunction

    // commands from the sequencer to the calendar unit
    typedef struct packed {
        logic load;      // take a new start year, clear the century split
        logic div_step;  // one step of the divide-by-100 split
        logic year_inc;  // advance to the next year
    } t_cal_ctrl;

    // shared adder result
    typedef struct packed {
        logic [REM_W-1:0] res;
        logic             borrow;  // valid for subtraction: a < b
    } t_alu_res;

endpackage

/* rtl/core/gda_if.sv */
// ----------------------------------------------------------------------------
// gda_in_if / gda_out_if
// Valid/ready channels carrying the start date transaction in and the
// resulting date transaction out.
// ----------------------------------------------------------------------------
interface gda_in_if import gda_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    start_year;
    logic [MONTH_W-1:0]   start_month;
    logic [DAY_W-1:0]     start_day;
    logic [ADD_W-1:0]     days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input  ready);
    modport sink   (input  valid, start_year, start_month, start_day, days_to_add,
                    output ready);
endinterface

interface gda_out_if import gda_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_W-1:0]     result_day;

    modport source (output valid, result_year, result_month, result_day,
                    input  ready);
    modport sink   (input  valid, result_year, result_month, result_day,
                    output ready);
endinterface

/* rtl/core/gregorian_date_add_days.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date with one shared adder under a small
// sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. After acceptance the sequencer splits the start
// year into centuries, sums the lengths of the months before the start month,
// adds the start day, then walks month by month from January of the start
// year until the remaining days fit. Every step goes through the single adder.
// The result then moves to an output register and the block is ready again on
// the next cycle; if an earlier result is still unclaimed in that register,
// the finished date waits and the block stays busy until the earlier result
// is taken.
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gda_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DOY  = 3'd2;
    localparam logic [2:0] S_DAY  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]         r_state,      n_state;
    logic [MONTH_W-1:0] r_m,          n_m;
    logic [MONTH_W-1:0] r_month,      n_month;
    logic [DAY_W-1:0]   r_day,        n_day;
    logic [REM_W-1:0]   r_rem,        n_rem;
    logic               r_out_valid,  n_out_valid;
    logic [YEAR_W-1:0]  r_out_year,   n_out_year;
    logic [MONTH_W-1:0] r_out_month,  n_out_month;
    logic [DAY_W-1:0]   r_out_day,    n_out_day;

    t_cal_ctrl          cal_ctrl;
    t_alu_res           alu_res;
    logic [REM_W-1:0]   alu_a;
    logic [REM_W-1:0]   alu_b;
    logic               alu_sub;
    logic [YEAR_W-1:0]  cal_acc;
    logic [YEAR_W-1:0]  cal_year;
    t_len               cal_len;

    gda_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    gda_cal u_cal (
        .i_clk   (i_clk),
        .i_ctrl  (cal_ctrl),
        .i_year  (i_in.start_year),
        .i_month (r_m),
        .i_alu   (alu_res),
        .o_acc   (cal_acc),
        .o_year  (cal_year),
        .o_len   (cal_len)
    );

    assign i_in.ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_month     = r_month;
        n_day       = r_day;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_out_year  = r_out_year;
        n_out_month = r_out_month;
        n_out_day   = r_out_day;
        cal_ctrl    = '0;
        alu_a       = r_rem;
        alu_b       = '0;
        alu_sub     = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    cal_ctrl.load = 1'b1;
                    n_month       = i_in.start_month;
                    n_day         = i_in.start_day;
                    n_rem         = {{(REM_W-ADD_W){1'b0}}, i_in.days_to_add};
                    n_m           = MONTH_JAN;
                    n_state       = S_DIV;
                end
            end
            // repeated subtraction of 100 from the year
            S_DIV: begin
                alu_a             = {{(REM_W-YEAR_W){1'b0}}, cal_acc};
                alu_b             = CENTURY;
                alu_sub           = 1'b1;
                cal_ctrl.div_step = 1'b1;
                if (alu_res.borrow) begin
                    n_state = S_DOY;
                end
            end
            // sum of the months before the start month
            S_DOY: begin
                alu_b = {{(REM_W-DAY_W){1'b0}}, cal_len};
                if (r_m < r_month) begin
                    n_rem = alu_res.res;
                    n_m   = r_m + 1'b1;
                end else begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                alu_b   = {{(REM_W-DAY_W){1'b0}}, r_day};
                n_rem   = alu_res.res;
                n_m     = MONTH_JAN;
                n_state = S_WALK;
            end
            // step over whole months while the remainder exceeds them
            S_WALK: begin
                alu_b   = {{(REM_W-DAY_W){1'b0}}, cal_len};
                alu_sub = 1'b1;
                if (!alu_res.borrow && (alu_res.res != '0)) begin
                    n_rem = alu_res.res;
                    if (r_m == MONTH_DEC) begin
                        n_m               = MONTH_JAN;
                        cal_ctrl.year_inc = 1'b1;
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            // hand over to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_year  = cal_year;
                    n_out_month = r_m;
                    n_out_day   = r_rem[DAY_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_m         <= n_m;
        r_month     <= n_month;
        r_day       <= n_day;
        r_rem       <= n_rem;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_year  = r_out_year;
    assign o_out.result_month = r_out_month;
    assign o_out.result_day   = r_out_day;

endmodule

/* rtl/core/gda_alu.sv */
// ----------------------------------------------------------------------------
// gda_alu
// Shared add/subtract unit used by every phase of the sequencer: the
// century split, the day-of-year sum, the start-day add and the month walk.
// ----------------------------------------------------------------------------
module gda_alu import gda_pkg::*; (
    input  logic [REM_W-1:0] i_a,
    input  logic [REM_W-1:0] i_b,
    input  logic             i_sub,
    output t_alu_res         o_res
);

    logic [REM_W:0]   sum;
    logic [REM_W-1:0] b_eff;

    // two's complement subtract through the same carry chain
    assign b_eff = i_sub ? ~i_b : i_b;
    assign sum   = {1'b0, i_a} + {1'b0, b_eff} + {{REM_W{1'b0}}, i_sub};

    assign o_res.res    = sum[REM_W-1:0];
    assign o_res.borrow = ~sum[REM_W];

endmodule

/* rtl/core/gda_cal.sv */
// ----------------------------------------------------------------------------
// gda_cal
// Calendar state: current year, its split into centuries and remainder
// (for the 100/400 leap rule) and the length of the month being visited.
// ----------------------------------------------------------------------------
module gda_cal import gda_pkg::*; (
    input  logic               i_clk,
    input  t_cal_ctrl          i_ctrl,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  t_alu_res           i_alu,
    output logic [YEAR_W-1:0]  o_acc,
    output logic [YEAR_W-1:0]  o_year,
    output t_len               o_len
);

    logic [YEAR_W-1:0]   r_year;
    logic [YEAR_W-1:0]   r_acc;
    logic [MOD100_W-1:0] r_mod100;
    logic [CENT_W-1:0]   r_cent;
    logic                leap;

    // divisible by 4, and not by 100 unless by 400
    assign leap = (r_year[1:0] == 2'b00) &&
                  ((r_mod100 != '0) || (r_cent == '0));

    // year register, century split and year stepping
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_year <= i_year;
            r_acc  <= i_year;
            r_cent <= '0;
        end else if (i_ctrl.div_step) begin
            if (i_alu.borrow) begin
                r_mod100 <= r_acc[MOD100_W-1:0];
            end else begin
                r_acc  <= i_alu.res[YEAR_W-1:0];
                r_cent <= r_cent + 1'b1;
            end
        end else if (i_ctrl.year_inc) begin
            if (r_year == {YEAR_W{1'b1}}) begin
                // year counter wraps to zero: restart the split
                r_year   <= '0;
                r_mod100 <= '0;
                r_cent   <= '0;
            end else begin
                r_year <= r_year + 1'b1;
                if (r_mod100 == MOD100_LAST) begin
                    r_mod100 <= '0;
                    r_cent   <= r_cent + 1'b1;
                end else begin
                    r_mod100 <= r_mod100 + 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_year = r_year;
    assign o_len  = f_month_len(i_month, leap);

endmodule

/* rtl/core/gda_checker.sv */
// ----------------------------------------------------------------------------
// gda_checker
// Port-level checks on the date-add block, bound to the top level.
// ----------------------------------------------------------------------------
module gda_checker import gda_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [YEAR_W-1:0]  i_out_year,
    input logic [MONTH_W-1:0] i_out_month,
    input logic [DAY_W-1:0]   i_out_day
);

    // one transaction at a time: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while previous transaction in flight");

    // the month walk only ever lands on a real month
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_month != '0) && (i_out_month <= MONTH_DEC)))
        else $error("result month out of range");

    // no result without an input transaction having gone in first
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(i_out_valid)) |-> $past(!i_in_ready))
        else $error("result appeared without a transaction in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_year) && $stable(i_out_month)
             && $stable(i_out_day)))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_year  (o_out.result_year),
    .i_out_month (o_out.result_month),
    .i_out_day   (o_out.result_day)
);
